>>> hdl/slotted_page_occupancy_map_unit_defines.svh
// Assertion macros for the slotted page occupancy map unit.
// Every macro samples on clock and is disabled while reset is high.
`ifndef SLOTTED_PAGE_OCCUPANCY_MAP_UNIT_DEFINES_SVH
`define SLOTTED_PAGE_OCCUPANCY_MAP_UNIT_DEFINES_SVH

// The condition must hold in the same cycle as the trigger.
`define SOPM_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The condition must hold in the cycle after the trigger.
`define SOPM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/sopm_pkg.sv
// Package for the slotted page occupancy map unit: field widths, operation codes, CSR and
// status constants, sequencer states and parameter defaults. Depends on nothing.
`timescale 1ns / 1ps

package sopm_pkg;

   localparam int DEF_PAGE_BYTES   = 4096;
   localparam int DEF_HEADER_BYTES = 12;
   localparam int DEF_MAX_SLOTS    = 2048;

   localparam int WORD_W     = 64;
   localparam int WORD_LSB   = 6;
   localparam int FUNC_W     = 2;
   localparam int SLOT_W     = 11;
   localparam int COUNT_W    = 12;
   localparam int REC_W      = 12;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic CSR_REG_RECORD_BYTES = 1'b0;

   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_RANGE = 1'b1;

   typedef enum logic [1:0] {
      FUNC_PUT    = 2'd0,
      FUNC_ERASE  = 2'd1,
      FUNC_QUERY  = 2'd2,
      FUNC_FORMAT = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_LOOKUP = 2'd1,
      ST_DIVIDE = 2'd2,
      ST_SCAN   = 2'd3
   } state_type;

endpackage

>>> hdl/slotted_page_occupancy_map_unit.sv
// Put, erase and query pass from accept through a lookup state and a scan state to rsp_strobe;
// an out-of-range slot skips the lookup. The scan reads one 64-bit word per cycle.
// Format replaces the lookup by a restoring divider and always ends its scan at the first word.
// busy stays high until the strobe cycle, and a new request may be accepted in that cycle.
// Synchronous reset clears the state, counts and row valid bits and sets record_bytes to 1.
`timescale 1ns / 1ps
`include "slotted_page_occupancy_map_unit_defines.svh"

module slotted_page_occupancy_map_unit #(
   parameter int PAGE_BYTES   = sopm_pkg::DEF_PAGE_BYTES,
   parameter int HEADER_BYTES = sopm_pkg::DEF_HEADER_BYTES,
   parameter int MAX_SLOTS    = sopm_pkg::DEF_MAX_SLOTS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [sopm_pkg::FUNC_W-1:0]     req_func,
   input  logic [sopm_pkg::SLOT_W-1:0]     req_slot,
   output logic                            rsp_strobe,
   output logic                            rsp_status,
   output logic                            rsp_was_occupied,
   output logic [sopm_pkg::SLOT_W-1:0]     rsp_lowest_free,
   output logic                            rsp_any_free,
   output logic [sopm_pkg::COUNT_W-1:0]    rsp_used_count,
   output logic [sopm_pkg::COUNT_W-1:0]    rsp_slot_total,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [sopm_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [sopm_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [sopm_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready
);
   import sopm_pkg::*;

   localparam int NWORDS  = (MAX_SLOTS + WORD_W - 1) / WORD_W;
   localparam int WIDX_W  = (NWORDS > 1) ? $clog2(NWORDS) : 1;
   localparam int CNT_W   = $clog2(MAX_SLOTS + 1);
   localparam int AREA    = PAGE_BYTES - HEADER_BYTES;
   localparam int AREA_W  = ($clog2(AREA + 1) < 2) ? 2 : $clog2(AREA + 1);
   localparam int DIVR_W  = REC_W + 1;
   localparam int REM_W   = DIVR_W + 1;
   localparam int ITER_W  = $clog2(AREA_W + 1);
   localparam int BASE_W  = WIDX_W + WORD_LSB;
   localparam int CMP_W   = ((BASE_W > CNT_W) ? BASE_W : CNT_W) + 1;

   state_type               state_ff, state_in;
   func_type                func_ff, func_in;
   logic [SLOT_W-1:0]       slot_ff, slot_in;
   logic                    status_ff, status_in;
   logic                    was_ff, was_in;
   logic [CNT_W-1:0]        slot_count_ff, slot_count_in;
   logic [CNT_W-1:0]        used_ff, used_in;
   logic [REC_W-1:0]        rec_ff, rec_in;
   logic [AREA_W-1:0]       dvd_ff, dvd_in;
   logic [DIVR_W-1:0]       rem_ff, rem_in;
   logic [ITER_W-1:0]       iter_ff, iter_in;
   logic [WIDX_W-1:0]       scan_idx_ff, scan_idx_in;
   logic [WIDX_W-1:0]       chk_idx_ff, chk_idx_in;
   logic                    chk_vld_ff, chk_vld_in;
   logic [NWORDS-1:0]       row_valid_ff, row_valid_in;

   logic                    rsp_strobe_ff, rsp_strobe_in;
   logic                    rsp_status_ff, rsp_status_in;
   logic                    rsp_was_ff, rsp_was_in;
   logic [SLOT_W-1:0]       rsp_lowest_ff, rsp_lowest_in;
   logic                    rsp_any_ff, rsp_any_in;
   logic [COUNT_W-1:0]      rsp_used_ff, rsp_used_in;
   logic [COUNT_W-1:0]      rsp_total_ff, rsp_total_in;

   logic [WORD_W-1:0]       bitmap_mem [NWORDS];
   logic [WORD_W-1:0]       rd_data_ff;
   logic                    rd_valid_ff;
   logic                    mem_we;
   logic [WIDX_W-1:0]       mem_waddr;
   logic [WIDX_W-1:0]       mem_raddr;
   logic [WORD_W-1:0]       mem_wdata;
   logic [WORD_W-1:0]       eff_word;

   logic                    accept;
   logic                    req_out_of_range;
   logic                    csr_write;
   logic [DIVR_W-1:0]       divisor;
   logic [REM_W-1:0]        rem_shift;
   logic                    rem_ge;
   logic [AREA_W-1:0]       quotient;

   logic [BASE_W-1:0]       chk_base;
   logic                    chk_in_range;
   logic [CNT_W-1:0]        chk_rem;
   logic [WORD_W-1:0]       chk_mask;
   logic [WORD_W-1:0]       free_vec;
   logic [WORD_LSB-1:0]     free_bit;
   logic                    chk_found;
   logic                    chk_last;
   logic                    chk_done;
   logic [WORD_LSB-1:0]     slot_bit;
   logic                    cur_bit;

   assign accept           = start && (state_ff == ST_IDLE);
   assign busy             = (state_ff != ST_IDLE);
   assign req_out_of_range = (32'(req_slot) >= 32'(slot_count_ff));
   assign eff_word         = rd_valid_ff ? rd_data_ff : '0;
   assign slot_bit         = slot_ff[WORD_LSB-1:0];
   assign cur_bit          = eff_word[slot_bit];

   assign csr_write = psel && penable && pwrite && pready
                      && (paddr[2] == CSR_REG_RECORD_BYTES);
   assign pready    = 1'b1;
   assign prdata    = (paddr[2] == CSR_REG_RECORD_BYTES) ? CSR_DATA_W'(rec_ff) : '0;

   assign divisor   = DIVR_W'(rec_ff) + DIVR_W'(1);
   assign rem_shift = {rem_ff, dvd_ff[AREA_W-1]};
   assign rem_ge    = (rem_shift >= REM_W'(divisor));
   assign quotient  = {dvd_ff[AREA_W-2:0], rem_ge};

   assign chk_base     = {chk_idx_ff, {WORD_LSB{1'b0}}};
   assign chk_in_range = (CMP_W'(slot_count_ff) > CMP_W'(chk_base));
   assign chk_rem      = CNT_W'(CMP_W'(slot_count_ff) - CMP_W'(chk_base));
   assign chk_last     = (CMP_W'(slot_count_ff) <= (CMP_W'(chk_base) + CMP_W'(WORD_W)));
   assign free_vec     = ~eff_word & chk_mask;
   assign chk_found    = (free_vec != '0);
   assign chk_done     = chk_vld_ff && (chk_found || chk_last);

   always_comb begin
      if (!chk_in_range) begin
         chk_mask = '0;
      end else if (32'(chk_rem) >= 32'(WORD_W)) begin
         chk_mask = '1;
      end else begin
         chk_mask = WORD_W'(((WORD_W + 1)'(1) << chk_rem) - (WORD_W + 1)'(1));
      end
   end

   always_comb begin
      free_bit = '0;
      for (int j = WORD_W - 1; j >= 0; j--) begin
         if (free_vec[j]) begin
            free_bit = WORD_LSB'(j);
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (func_type'(req_func) == FUNC_FORMAT) begin
                  state_in = ST_DIVIDE;
               end else if (req_out_of_range) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_LOOKUP;
               end
            end
         end
         ST_LOOKUP: begin
            state_in = ST_SCAN;
         end
         ST_DIVIDE: begin
            if (iter_ff == ITER_W'(1)) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (chk_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      func_in       = func_ff;
      slot_in       = slot_ff;
      status_in     = status_ff;
      was_in        = was_ff;
      slot_count_in = slot_count_ff;
      used_in       = used_ff;
      rec_in        = csr_write ? pwdata[REC_W-1:0] : rec_ff;
      dvd_in        = dvd_ff;
      rem_in        = rem_ff;
      iter_in       = iter_ff;
      scan_idx_in   = scan_idx_ff;
      chk_idx_in    = chk_idx_ff;
      chk_vld_in    = 1'b0;
      row_valid_in  = row_valid_ff;
      mem_we        = 1'b0;
      mem_waddr     = WIDX_W'(slot_ff >> WORD_LSB);
      mem_wdata     = eff_word;
      mem_raddr     = WIDX_W'(req_slot >> WORD_LSB);
      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_was_in    = rsp_was_ff;
      rsp_lowest_in = rsp_lowest_ff;
      rsp_any_in    = rsp_any_ff;
      rsp_used_in   = rsp_used_ff;
      rsp_total_in  = rsp_total_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               func_in     = func_type'(req_func);
               slot_in     = req_slot;
               status_in   = STATUS_OK;
               was_in      = 1'b0;
               scan_idx_in = '0;
               dvd_in      = AREA_W'(AREA);
               rem_in      = '0;
               iter_in     = ITER_W'(AREA_W);
               if (func_type'(req_func) != FUNC_FORMAT && req_out_of_range) begin
                  status_in = STATUS_RANGE;
               end
            end
         end
         ST_LOOKUP: begin
            was_in = cur_bit;
            if (func_ff == FUNC_PUT && !cur_bit) begin
               mem_we             = 1'b1;
               mem_wdata[slot_bit] = 1'b1;
               used_in            = used_ff + CNT_W'(1);
            end else if (func_ff == FUNC_ERASE && cur_bit) begin
               mem_we             = 1'b1;
               mem_wdata[slot_bit] = 1'b0;
               used_in            = used_ff - CNT_W'(1);
            end
            if (mem_we) begin
               row_valid_in[mem_waddr] = 1'b1;
            end
         end
         ST_DIVIDE: begin
            rem_in  = rem_ge ? DIVR_W'(rem_shift - REM_W'(divisor)) : DIVR_W'(rem_shift);
            dvd_in  = quotient;
            iter_in = iter_ff - ITER_W'(1);
            if (iter_ff == ITER_W'(1)) begin
               slot_count_in = (32'(quotient) > 32'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS)
                                                                : CNT_W'(quotient);
               row_valid_in  = '0;
               used_in       = '0;
            end
         end
         ST_SCAN: begin
            mem_raddr   = scan_idx_ff;
            scan_idx_in = scan_idx_ff + WIDX_W'(1);
            chk_idx_in  = scan_idx_ff;
            chk_vld_in  = 1'b1;
            if (chk_done) begin
               chk_vld_in    = 1'b0;
               rsp_strobe_in = 1'b1;
               rsp_status_in = status_ff;
               rsp_was_in    = was_ff;
               rsp_any_in    = chk_found;
               rsp_lowest_in = chk_found ? SLOT_W'(CMP_W'(chk_base) + CMP_W'(free_bit)) : '0;
               rsp_used_in   = COUNT_W'(used_ff);
               rsp_total_in  = COUNT_W'(slot_count_ff);
            end
         end
         default: begin
            chk_vld_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         bitmap_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff  <= bitmap_mem[mem_raddr];
      rd_valid_ff <= row_valid_ff[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         slot_count_ff <= '0;
         used_ff       <= '0;
         rec_ff        <= REC_W'(1);
         row_valid_ff  <= '0;
         chk_vld_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         slot_count_ff <= slot_count_in;
         used_ff       <= used_in;
         rec_ff        <= rec_in;
         row_valid_ff  <= row_valid_in;
         chk_vld_ff    <= chk_vld_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      slot_ff       <= slot_in;
      status_ff     <= status_in;
      was_ff        <= was_in;
      dvd_ff        <= dvd_in;
      rem_ff        <= rem_in;
      iter_ff       <= iter_in;
      scan_idx_ff   <= scan_idx_in;
      chk_idx_ff    <= chk_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_was_ff    <= rsp_was_in;
      rsp_lowest_ff <= rsp_lowest_in;
      rsp_any_ff    <= rsp_any_in;
      rsp_used_ff   <= rsp_used_in;
      rsp_total_ff  <= rsp_total_in;
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_was_occupied = rsp_was_ff;
   assign rsp_lowest_free  = rsp_lowest_ff;
   assign rsp_any_free     = rsp_any_ff;
   assign rsp_used_count   = rsp_used_ff;
   assign rsp_slot_total   = rsp_total_ff;

   `SOPM_ASSERT_IMPL(a_strobe_in_idle, rsp_strobe, state_ff == ST_IDLE, "strobe outside idle")
   `SOPM_ASSERT_NEXT(a_accept_sets_busy, start && !busy, busy, "accepted request not busy")
   `SOPM_ASSERT_IMPL(a_used_within_total, 1'b1, used_ff <= slot_count_ff, "used count too big")
   `SOPM_ASSERT_IMPL(a_range_not_occupied, rsp_strobe && rsp_status, !rsp_was_occupied,
      "rejected request reports occupancy")
   `SOPM_ASSERT_IMPL(a_free_below_total, rsp_strobe && rsp_any_free,
      COUNT_W'(rsp_lowest_free) < rsp_slot_total, "lowest free slot beyond slot count")

endmodule
